// ----- hw/rtl/clipped_glyph_blit_framebuffer_defines.svh -----
// ----------------------------------------------------------------------------
// Glyph blit frame buffer: assertion macros
// Shared concurrent assertion wrappers, clocked and reset-qualified.
// ----------------------------------------------------------------------------
`ifndef CLIPPED_GLYPH_BLIT_FRAMEBUFFER_DEFINES_SVH
`define CLIPPED_GLYPH_BLIT_FRAMEBUFFER_DEFINES_SVH

// Plain property, checked on every rising edge outside reset
`define CGBF_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Same-cycle implication
`define CGBF_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication
`define CGBF_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- hw/rtl/cgbf_pkg.sv -----
// ----------------------------------------------------------------------------
// cgbf_pkg
// Types, codes and helpers for the glyph blit frame buffer.
// ----------------------------------------------------------------------------
package cgbf_pkg;

	// Fixed geometry
	localparam int MATRIX_ROWS = 8;
	localparam logic [3:0] GLYPH_MAX = 4'd8;

	// Item modes
	localparam logic MODE_BLIT = 1'b0;
	localparam logic MODE_READ = 1'b1;

	// Most transactions that may sit between input and output handshakes
	localparam int OUTSTANDING_MAX = 2;

	// Sequencer states, one-hot
	typedef enum logic [5:0] {
		S_IDLE  = 6'b000001,
		S_ROW   = 6'b000010,
		S_BYTE  = 6'b000100,
		S_MRG   = 6'b001000,
		S_RDATA = 6'b010000,
		S_DONE  = 6'b100000
	} state_t;

	// Bit reversal of one byte
	function automatic logic [7:0] rev8(input logic [7:0] b);
		logic [7:0] r;
		for (int i = 0; i < 8; i++) begin
			r[i] = b[7 - i];
		end
		return r;
	endfunction

endpackage

// ----- hw/rtl/cgbf_ram.sv -----
// ----------------------------------------------------------------------------
// cgbf_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module cgbf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port, registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ----- hw/rtl/clipped_glyph_blit_framebuffer.sv -----
// ----------------------------------------------------------------------------
// clipped_glyph_blit_framebuffer
// One-bit-per-pixel 8-row frame buffer with clipped glyph blits and byte reads.
// ----------------------------------------------------------------------------
//  channel | handshake               | payload
//  --------+-------------------------+------------------------------------------
//  in      | in_valid / in_stall     | mode, glyph_rows, glyph_width,
//          |                         | glyph_height, col_origin, row_origin,
//          |                         | read_address
//  out     | out_valid / out_stall   | read_data
//  cfg     | cfg_valid / cfg_ready   | cfg_data (modules_in_use)
//
// Read: the stored byte passes S_RDATA into res_q, then S_DONE into the output
// register. Blit: each touched byte takes a read step (S_BYTE) and a merge/write
// step (S_MRG) on the frame store, through one shared merge unit.
// Reset clears the control state and per-byte valid flags; unwritten bytes read 0.
// The input is stalled while an item is in work; a finished result waits in the
// output register, so the next item may be taken while out_stall is high.
// ----------------------------------------------------------------------------
module clipped_glyph_blit_framebuffer #(
	parameter int MAX_MODULES = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	// configuration
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [3:0]  cfg_data,
	// input items
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        mode,
	input  logic [63:0] glyph_rows,
	input  logic [3:0]  glyph_width,
	input  logic [3:0]  glyph_height,
	input  logic signed [6:0] col_origin,
	input  logic signed [3:0] row_origin,
	input  logic [5:0]  read_address,
	// results
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  read_data
);

	import cgbf_pkg::*;

	localparam int STORE = MAX_MODULES * MATRIX_ROWS;
	localparam int AW    = $clog2(STORE);

	state_t state_q;

	logic [3:0]  mods_q;
	logic [3:0]  mods;
	logic        mode_q;
	logic [63:0] glyph_rows_q;
	logic [3:0]  w_q;
	logic [3:0]  h_q;
	logic [6:0]  col_origin_q;
	logic [3:0]  row_origin_q;
	logic        rd_in_range_q;
	logic [3:0]  r_q;
	logic        sel_q;
	logic [AW-1:0] addr_q;
	logic [7:0]  bmask_q;
	logic [7:0]  bdata_q;
	logic [7:0]  res_q;
	logic        out_valid_q;
	logic [7:0]  read_data_q;
	logic [STORE-1:0] vld_q;
	logic        vld_rd_q;

	logic        in_acc;
	logic        out_free;
	logic [4:0]  mr;
	logic        row_ok;
	logic [7:0]  gb;
	logic [7:0]  wmask8;
	logic [7:0]  colbits;
	logic [15:0] data16;
	logic [15:0] mask16;
	logic [5:0]  kb;
	logic [5:0]  kb_sel;
	logic        byte_ok;
	logic [7:0]  cur_mask;
	logic [7:0]  cur_data;
	logic [6:0]  row_base;
	logic [7:0]  byte_idx;
	logic [AW-1:0] byte_addr;
	logic [AW-1:0] raddr;
	logic [7:0]  rdata;
	logic [7:0]  old_byte;
	logic [7:0]  merged;
	logic        we;

	assign cfg_ready = 1'b1;
	assign in_stall  = (state_q != S_IDLE);
	assign in_acc    = in_valid && !in_stall;
	assign out_valid = out_valid_q;
	assign read_data = read_data_q;
	assign out_free  = !out_valid_q || !out_stall;

	// Module count in use, capped at the built width
	always_comb begin
		mods = (int'(mods_q) > MAX_MODULES) ? 4'(MAX_MODULES) : mods_q;
	end

	// Current glyph row: matrix row and clipping
	assign mr     = {row_origin_q[3], row_origin_q} + {1'b0, r_q};
	assign row_ok = (mr[4:3] == 2'b00);
	assign gb     = glyph_rows_q[{r_q[2:0], 3'b000} +: 8];

	// Glyph columns placed in a two-byte window starting at byte col_origin/8
	assign wmask8  = 8'((16'd1 << w_q) - 16'd1);
	assign colbits = rev8(gb) >> (4'd8 - w_q);
	assign data16  = {8'h00, colbits & wmask8} << col_origin_q[2:0];
	assign mask16  = {8'h00, wmask8} << col_origin_q[2:0];
	assign cur_mask = sel_q ? mask16[15:8] : mask16[7:0];
	assign cur_data = sel_q ? data16[15:8] : data16[7:0];

	// Byte column index (signed), column clipping
	assign kb      = col_origin_q[6:1] >> 2 | {{3{col_origin_q[6]}}, 3'b000};
	assign byte_ok = !kb_sel[5] && (kb_sel[4:0] < {1'b0, mods}) && (cur_mask != 8'h00);

	assign kb_sel = kb + {5'b00000, sel_q};

	// Store address of the current byte
	assign row_base  = mr[2:0] * mods;
	assign byte_idx  = {1'b0, row_base} + {3'b000, kb_sel[4:0]};
	assign byte_addr = AW'(byte_idx);

	// Shared merge unit
	assign old_byte = vld_rd_q ? rdata : 8'h00;
	assign merged   = (old_byte & ~bmask_q) | (bdata_q & bmask_q);
	assign we       = (state_q == S_MRG);

	// Read address: port address while idle, else the byte in work
	assign raddr = (state_q == S_IDLE) ? AW'(read_address) : byte_addr;

	cgbf_ram #(
		.WIDTH (8),
		.DEPTH (STORE)
	) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (addr_q),
		.wdata (merged),
		.raddr (raddr),
		.rdata (rdata)
	);

	// Configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mods_q <= 4'd4;
		end else if (cfg_valid && cfg_ready) begin
			mods_q <= cfg_data;
		end
	end

	// Per-byte written flags, read alongside the RAM
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			vld_rd_q <= 1'b0;
		end else begin
			vld_rd_q <= vld_q[raddr];
			if (we) begin
				vld_q[addr_q] <= 1'b1;
			end
		end
	end

	// Item payload, held for the duration of the transaction
	always_ff @(posedge clk) begin
		if (in_acc) begin
			mode_q        <= mode;
			glyph_rows_q  <= glyph_rows;
			w_q           <= (glyph_width > GLYPH_MAX) ? GLYPH_MAX : glyph_width;
			h_q           <= (glyph_height > GLYPH_MAX) ? GLYPH_MAX : glyph_height;
			col_origin_q  <= col_origin;
			row_origin_q  <= row_origin;
			rd_in_range_q <= (int'(read_address) < STORE);
		end
		if (state_q == S_BYTE && byte_ok) begin
			addr_q  <= byte_addr;
			bmask_q <= cur_mask;
			bdata_q <= cur_data;
		end
		if (out_valid_q == 1'b0 || !out_stall) begin
			if (state_q == S_DONE) begin
				read_data_q <= res_q;
			end
		end
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			r_q         <= 4'd0;
			sel_q       <= 1'b0;
			res_q       <= 8'h00;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						res_q <= 8'h00;
						r_q   <= 4'd0;
						sel_q <= 1'b0;
						state_q <= (mode == MODE_READ) ? S_RDATA : S_ROW;
					end
				end
				S_ROW: begin
					if (r_q >= h_q) begin
						state_q <= S_DONE;
					end else if (row_ok) begin
						sel_q   <= 1'b0;
						state_q <= S_BYTE;
					end else begin
						r_q <= r_q + 4'd1;
					end
				end
				S_BYTE: begin
					if (byte_ok) begin
						state_q <= S_MRG;
					end else if (!sel_q) begin
						sel_q <= 1'b1;
					end else begin
						r_q     <= r_q + 4'd1;
						state_q <= S_ROW;
					end
				end
				S_MRG: begin
					if (!sel_q) begin
						sel_q   <= 1'b1;
						state_q <= S_BYTE;
					end else begin
						r_q     <= r_q + 4'd1;
						state_q <= S_ROW;
					end
				end
				S_RDATA: begin
					res_q   <= (rd_in_range_q && vld_rd_q && mode_q == MODE_READ) ?
						rdata : 8'h00;
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

// ----- hw/rtl/cgbf_checker.sv -----
// ----------------------------------------------------------------------------
// cgbf_checker
// Port-level checks on the glyph blit frame buffer, bound to the top level.
// ----------------------------------------------------------------------------
`include "clipped_glyph_blit_framebuffer_defines.svh"

module cgbf_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_stall,
	input logic       out_valid,
	input logic       out_stall,
	input logic [7:0] read_data
);

	import cgbf_pkg::*;

	logic       in_acc;
	logic       out_acc;
	logic [2:0] cnt_q;

	assign in_acc  = in_valid && !in_stall;
	assign out_acc = out_valid && !out_stall;

	// Transactions taken in but not yet delivered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 3'd0;
		end else begin
			cnt_q <= cnt_q + {2'b00, in_acc} - {2'b00, out_acc};
		end
	end

	`CGBF_ASSERT_NXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid && $stable(read_data), "stalled result changed")
	`CGBF_ASSERT_NXT(a_busy_after_accept, clk, arst_n, in_acc, in_stall, "input not stalled while item in work")
	`CGBF_ASSERT_IMP(a_no_invented, clk, arst_n, out_valid, cnt_q != 3'd0, "result without an item")
	`CGBF_ASSERT(a_outstanding, clk, arst_n, int'(cnt_q) <= OUTSTANDING_MAX, "too many items in flight")

endmodule

bind clipped_glyph_blit_framebuffer cgbf_checker u_cgbf_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.read_data (read_data)
);
